@@ rtl/yuvs_pkg.sv @@
`timescale 1ns / 1ps

package yuvs_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int DIM_W   = 9;
	localparam int OUT_W   = 11;
	localparam int CRD_W   = 12;
	localparam int ADR_MIN = CRD_W + DIM_W + 1;
	localparam int PROD_W  = 22;

	localparam logic [1:0] FMT_444 = 2'd0;
	localparam logic [1:0] FMT_422 = 2'd1;
	localparam logic [1:0] FMT_420 = 2'd2;
	localparam logic [1:0] FMT_RSV = 2'd3;

	localparam logic [1:0] PLANE_Y   = 2'd0;
	localparam logic [1:0] PLANE_U   = 2'd1;
	localparam logic [1:0] PLANE_V   = 2'd2;
	localparam logic [1:0] PLANE_RSV = 2'd3;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_RENDER = 1'b1;

	localparam logic [1:0] CFG_FMT    = 2'd0;
	localparam logic [1:0] CFG_SCALE  = 2'd1;
	localparam logic [1:0] CFG_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_HEIGHT = 2'd3;

	localparam logic [1:0]       FMT_RST    = FMT_444;
	localparam logic [2:0]       SCALE_RST  = 3'd0;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;

	localparam logic signed [11:0] K_Y  = 12'sd298;
	localparam logic signed [11:0] K_RV = 12'sd409;
	localparam logic signed [11:0] K_GU = 12'sd100;
	localparam logic signed [11:0] K_GV = 12'sd208;
	localparam logic signed [11:0] K_BU = 12'sd516;
	localparam logic signed [9:0]  Y_OFS = 10'sd16;
	localparam logic signed [9:0]  C_OFS = 10'sd128;
	localparam logic signed [PROD_W-1:0] RND = 22'sd128;

	typedef struct packed {
		logic [1:0]       pixel_format;
		logic [2:0]       scale_log2;
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] src_height;
	} cfg_t;

	typedef struct packed {
		logic       render;
		logic       oor;
		logic       wr_ok;
		logic [1:0] plane;
		logic [7:0] sample;
		logic       a_ok;
		logic       b_ok;
	} acc_t;

	typedef struct packed {
		logic oor;
		logic y_ok;
		logic c_ok;
	} pix_t;

endpackage

@@ rtl/yuv_plane_scale_to_rgb.sv @@
// Planar Y/U/V frame store with nearest-neighbor scaling (x4, x2, x1, /2, /4) and
// BT.601 integer conversion to clipped 8-bit RGB. Write items load one sample of one
// plane; render items return one pixel each, in order, writes return nothing. One item
// is accepted per cycle while the output is not held: every stage holds one item and
// each plane memory takes its write and its read in the same stage. A render result
// passes the first and second address stages, the registered store read, the multiplier
// stage and the output register; a held output stalls the input only once the empty
// stages ahead of it have filled. Writes and reads reach the memories in the same stage,
// so a render sees every earlier write. The stores are not cleared after reset: render
// only locations that have been written. Configuration is taken at any time but must be
// changed only while the pipeline is empty.
`timescale 1ns / 1ps

module yuv_plane_scale_to_rgb #(
	parameter int MAX_WIDTH  = yuvs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = yuvs_pkg::MAX_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [1:0] plane,
	input  logic [9:0] row,
	input  logic [9:0] col,
	input  logic [7:0] sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       out_of_range
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	yuvs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= yuvs_pkg::FMT_RST;
			cfg_q.scale_log2   <= yuvs_pkg::SCALE_RST;
			cfg_q.src_width    <= yuvs_pkg::WIDTH_RST;
			cfg_q.src_height   <= yuvs_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				yuvs_pkg::CFG_FMT:    cfg_q.pixel_format <= cfg_data[1:0];
				yuvs_pkg::CFG_SCALE:  cfg_q.scale_log2   <= cfg_data[2:0];
				yuvs_pkg::CFG_WIDTH:  cfg_q.src_width    <= cfg_data;
				yuvs_pkg::CFG_HEIGHT: cfg_q.src_height   <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage valid with ready chain; bubbles collapse while the output waits
	logic v1_q, v2_q, v3_q, v4_q;
	logic r1, r2, r3, r4, r5;

	assign r5 = !out_valid || out_ready;
	assign r4 = !v4_q || r5;
	assign r3 = !v3_q || r4;
	assign r2 = !v2_q || r3;
	assign r1 = !v1_q || r2;
	assign in_ready = r1;

	yuvs_pkg::acc_t    ctl_s2;
	logic [ADDR_W-1:0] a_addr_s2, b_addr_s2;
	yuvs_pkg::pix_t    pix_s3;
	logic [7:0]        y_s3, u_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			v4_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (r1)
				v1_q <= in_valid;
			if (r2)
				v2_q <= v1_q;
			if (r3)
				v3_q <= v2_q && ctl_s2.render;
			if (r4)
				v4_q <= v3_q;
			if (r5)
				out_valid <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (r3) begin
			pix_s3.oor  <= ctl_s2.oor;
			pix_s3.y_ok <= ctl_s2.a_ok;
			pix_s3.c_ok <= ctl_s2.b_ok;
		end
	end

	yuvs_addr #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.DEPTH     (DEPTH),
		.ADDR_W    (ADDR_W)
	) u_addr (
		.clk      (clk),
		.en1      (r1),
		.en2      (r2),
		.cfg      (cfg_q),
		.action   (action),
		.plane    (plane),
		.row      (row),
		.col      (col),
		.sample   (sample),
		.ctl_s2   (ctl_s2),
		.a_addr_s2(a_addr_s2),
		.b_addr_s2(b_addr_s2)
	);

	yuvs_store #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk   (clk),
		.en    (r3 && v2_q),
		.ctl   (ctl_s2),
		.a_addr(a_addr_s2),
		.b_addr(b_addr_s2),
		.y_s3  (y_s3),
		.u_s3  (u_s3),
		.v_s3  (v_s3)
	);

	yuvs_csc u_csc (
		.clk         (clk),
		.en4         (r4),
		.en5         (r5),
		.pix_s3      (pix_s3),
		.y_s3        (y_s3),
		.u_s3        (u_s3),
		.v_s3        (v_s3),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_of_range(out_of_range)
	);

endmodule

@@ rtl/yuvs_addr.sv @@
`timescale 1ns / 1ps

module yuvs_addr #(
	parameter int MAX_WIDTH  = yuvs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = yuvs_pkg::MAX_HEIGHT_DEF,
	parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
	parameter int ADDR_W     = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                en1,
	input  logic                en2,
	input  yuvs_pkg::cfg_t      cfg,
	input  logic                action,
	input  logic [1:0]          plane,
	input  logic [9:0]          row,
	input  logic [9:0]          col,
	input  logic [7:0]          sample,
	output yuvs_pkg::acc_t      ctl_s2,
	output logic [ADDR_W-1:0]   a_addr_s2,
	output logic [ADDR_W-1:0]   b_addr_s2
);

	localparam int AW = (ADDR_W > yuvs_pkg::ADR_MIN) ? ADDR_W : yuvs_pkg::ADR_MIN;
	localparam int CW = yuvs_pkg::CRD_W;
	localparam int DW = yuvs_pkg::DIM_W;
	localparam int OW = yuvs_pkg::OUT_W;

	function automatic logic [CW-1:0] map_crd(input logic [9:0] x, input logic up,
			input logic dn, input logic [1:0] sh);
		logic [CW-1:0] r;
		if (up)
			r = CW'(x >> sh);
		else if (dn)
			r = CW'(x) << sh;
		else
			r = CW'(x);
		return r;
	endfunction

	function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v, input int maxv);
		logic [DW-1:0] r;
		if (v == '0)
			r = DW'(1);
		else if (32'(v) > 32'(maxv))
			r = DW'(maxv);
		else
			r = v;
		return r;
	endfunction

	logic [1:0]        fmt;
	logic signed [2:0] n;
	logic signed [2:0] nneg;
	logic              up, dn;
	logic [1:0]        sh;
	logic [DW-1:0]     w, h, cw, ch, pw, ph;
	logic [OW-1:0]     ow, oh;
	logic [CW-1:0]     lr, lc, cr, cc;
	logic [2:0]        sh1;
	logic              oor, wr_ok;

	always_comb begin
		fmt = (cfg.pixel_format == yuvs_pkg::FMT_RSV) ? yuvs_pkg::FMT_420 : cfg.pixel_format;
		if ($signed(cfg.scale_log2) > 3'sd2)
			n = 3'sd2;
		else if ($signed(cfg.scale_log2) < -3'sd2)
			n = -3'sd2;
		else
			n = $signed(cfg.scale_log2);
		nneg = -n;
		up = n > 3'sd0;
		dn = n < 3'sd0;
		sh = up ? n[1:0] : (dn ? nneg[1:0] : 2'd0);
		sh1 = {1'b0, sh} + 3'd1;

		w = sat_dim(cfg.src_width, MAX_WIDTH);
		h = sat_dim(cfg.src_height, MAX_HEIGHT);
		cw = (fmt == yuvs_pkg::FMT_444) ? w : DW'((10'(w) + 10'd1) >> 1);
		ch = (fmt == yuvs_pkg::FMT_420) ? DW'((10'(h) + 10'd1) >> 1) : h;

		if (up) begin
			ow = OW'(w) << sh;
			oh = OW'(h) << sh;
		end else begin
			ow = OW'(w >> sh);
			oh = OW'(h >> sh);
		end

		lr = map_crd(row, up, dn, sh);
		lc = map_crd(col, up, dn, sh);
		cc = (fmt == yuvs_pkg::FMT_444) ? lc : map_crd({1'b0, col[9:1]}, up, dn, sh);
		if (fmt != yuvs_pkg::FMT_420)
			cr = lr;
		else if (!dn)
			cr = CW'(row >> sh1);
		else
			cr = CW'({1'b0, row[9:1]}) << sh;

		pw = (plane == yuvs_pkg::PLANE_Y) ? w : cw;
		ph = (plane == yuvs_pkg::PLANE_Y) ? h : ch;
		wr_ok = (plane != yuvs_pkg::PLANE_RSV) && (row < 10'(ph)) && (col < 10'(pw));
		oor = (OW'(row) >= oh) || (OW'(col) >= ow);
	end

	// stage 1: mapped coordinates; slot A carries the write address terms on writes
	logic          render_s1, oor_s1, wr_ok_s1;
	logic [1:0]    plane_s1;
	logic [7:0]    sample_s1;
	logic [CW-1:0] ar_s1, ac_s1, br_s1, bc_s1;
	logic [DW-1:0] as_s1, bs_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			render_s1 <= action == yuvs_pkg::ACT_RENDER;
			oor_s1    <= oor;
			wr_ok_s1  <= wr_ok;
			plane_s1  <= plane;
			sample_s1 <= sample;
			ar_s1     <= (action == yuvs_pkg::ACT_RENDER) ? lr : CW'(row);
			ac_s1     <= (action == yuvs_pkg::ACT_RENDER) ? lc : CW'(col);
			as_s1     <= (action == yuvs_pkg::ACT_RENDER) ? w : pw;
			br_s1     <= cr;
			bc_s1     <= cc;
			bs_s1     <= cw;
		end
	end

	// stage 2: row * stride + column
	logic [CW+DW-1:0] a_prod, b_prod;
	logic [AW-1:0]    a_sum, b_sum;
	logic             a_ok, b_ok;

	always_comb begin
		a_prod = ar_s1 * as_s1;
		b_prod = br_s1 * bs_s1;
		a_sum  = AW'(a_prod) + AW'(ac_s1);
		b_sum  = AW'(b_prod) + AW'(bc_s1);
		a_ok   = 32'(a_sum) < 32'(DEPTH);
		b_ok   = 32'(b_sum) < 32'(DEPTH);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ctl_s2.render <= render_s1;
			ctl_s2.oor    <= oor_s1;
			ctl_s2.wr_ok  <= wr_ok_s1 && a_ok;
			ctl_s2.plane  <= plane_s1;
			ctl_s2.sample <= sample_s1;
			ctl_s2.a_ok   <= a_ok;
			ctl_s2.b_ok   <= b_ok;
			a_addr_s2     <= a_sum[ADDR_W-1:0];
			b_addr_s2     <= b_sum[ADDR_W-1:0];
		end
	end

endmodule

@@ rtl/yuvs_store.sv @@
`timescale 1ns / 1ps

module yuvs_store #(
	parameter int DEPTH  = yuvs_pkg::MAX_WIDTH_DEF * yuvs_pkg::MAX_HEIGHT_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              en,
	input  yuvs_pkg::acc_t    ctl,
	input  logic [ADDR_W-1:0] a_addr,
	input  logic [ADDR_W-1:0] b_addr,
	output logic [7:0]        y_s3,
	output logic [7:0]        u_s3,
	output logic [7:0]        v_s3
);

	logic [7:0] y_mem [DEPTH];
	logic [7:0] u_mem [DEPTH];
	logic [7:0] v_mem [DEPTH];

	logic wr, rd;

	assign wr = en && !ctl.render && ctl.wr_ok;
	assign rd = en && ctl.render;

	always_ff @(posedge clk) begin
		if (wr && ctl.plane == yuvs_pkg::PLANE_Y)
			y_mem[a_addr] <= ctl.sample;
		if (rd)
			y_s3 <= y_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr && ctl.plane == yuvs_pkg::PLANE_U)
			u_mem[a_addr] <= ctl.sample;
		if (rd)
			u_s3 <= u_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		if (wr && ctl.plane == yuvs_pkg::PLANE_V)
			v_mem[a_addr] <= ctl.sample;
		if (rd)
			v_s3 <= v_mem[b_addr];
	end

endmodule

@@ rtl/yuvs_csc.sv @@
`timescale 1ns / 1ps

module yuvs_csc (
	input  logic           clk,
	input  logic           en4,
	input  logic           en5,
	input  yuvs_pkg::pix_t pix_s3,
	input  logic [7:0]     y_s3,
	input  logic [7:0]     u_s3,
	input  logic [7:0]     v_s3,
	output logic [7:0]     red,
	output logic [7:0]     green,
	output logic [7:0]     blue,
	output logic           out_of_range
);

	localparam int PW = yuvs_pkg::PROD_W;

	function automatic logic [7:0] clip8(input logic signed [PW-1:0] t);
		logic [7:0] r;
		if (t < 0)
			r = 8'd0;
		else if (t[PW-1:16] != '0)
			r = 8'd255;
		else
			r = t[15:8];
		return r;
	endfunction

	logic signed [9:0] yc, ud, ve;

	always_comb begin
		yc = $signed({2'b00, pix_s3.y_ok ? y_s3 : 8'd0}) - yuvs_pkg::Y_OFS;
		ud = $signed({2'b00, pix_s3.c_ok ? u_s3 : 8'd0}) - yuvs_pkg::C_OFS;
		ve = $signed({2'b00, pix_s3.c_ok ? v_s3 : 8'd0}) - yuvs_pkg::C_OFS;
	end

	logic signed [PW-1:0] py_s4, prv_s4, pgu_s4, pgv_s4, pbu_s4;
	logic                 oor_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			py_s4  <= PW'(yc) * PW'(yuvs_pkg::K_Y);
			prv_s4 <= PW'(ve) * PW'(yuvs_pkg::K_RV);
			pgu_s4 <= PW'(ud) * PW'(yuvs_pkg::K_GU);
			pgv_s4 <= PW'(ve) * PW'(yuvs_pkg::K_GV);
			pbu_s4 <= PW'(ud) * PW'(yuvs_pkg::K_BU);
			oor_s4 <= pix_s3.oor;
		end
	end

	logic signed [PW-1:0] tr, tg, tb;

	always_comb begin
		tr = py_s4 + prv_s4 + yuvs_pkg::RND;
		tg = py_s4 - pgu_s4 - pgv_s4 + yuvs_pkg::RND;
		tb = py_s4 + pbu_s4 + yuvs_pkg::RND;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			red          <= oor_s4 ? 8'd0 : clip8(tr);
			green        <= oor_s4 ? 8'd0 : clip8(tg);
			blue         <= oor_s4 ? 8'd0 : clip8(tb);
			out_of_range <= oor_s4;
		end
	end

endmodule
